[hdl/video_register_port_scroll_unit_macros.svh]
// Assertion macros shared by the checker of the scroll unit
`ifndef VIDEO_REGISTER_PORT_SCROLL_UNIT_MACROS_SVH
`define VIDEO_REGISTER_PORT_SCROLL_UNIT_MACROS_SVH

// antecedent true implies consequent in the same cycle
`define VRPSU_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// antecedent true implies consequent in the next cycle
`define VRPSU_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hdl/vrpsu_pkg.sv]
// Types, codes and widths shared by the scroll unit modules
package vrpsu_pkg;

    localparam int KIND_W  = 3;
    localparam int REG_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 16;
    localparam int MADDR_W = 14;
    localparam int FX_W    = 3;
    localparam int STAT_W  = 3;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 6;
    localparam int OUT_TDATA_W = 72;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CPU_READ  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CPU_WRITE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INC_X     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INC_Y     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COPY_X    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_COPY_Y    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_VBL_START = 3'd6;
    localparam logic [KIND_W-1:0] KIND_VBL_END   = 3'd7;

    // register indexes
    localparam logic [REG_W-1:0] REG_CONTROL = 3'd0;
    localparam logic [REG_W-1:0] REG_MASK    = 3'd1;
    localparam logic [REG_W-1:0] REG_STATUS  = 3'd2;
    localparam logic [REG_W-1:0] REG_OAMADDR = 3'd3;
    localparam logic [REG_W-1:0] REG_OAMDATA = 3'd4;
    localparam logic [REG_W-1:0] REG_SCROLL  = 3'd5;
    localparam logic [REG_W-1:0] REG_ADDRESS = 3'd6;
    localparam logic [REG_W-1:0] REG_DATA    = 3'd7;

    localparam logic [MADDR_W-1:0] PALETTE_BASE = 14'h3F00;
    localparam logic [4:0] COARSE_LAST = 5'd31;
    localparam logic [4:0] TILE_ROW_LAST_VIS = 5'd29;
    localparam logic [ADDR_W-1:0] STEP_ROW = 16'd32;
    localparam logic [ADDR_W-1:0] STEP_ONE = 16'd1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [REG_W-1:0]  reg_index;
        logic [BYTE_W-1:0] write_data;
        logic [BYTE_W-1:0] mem_read_data;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  read_data;
        logic               mem_write_strobe;
        logic [MADDR_W-1:0] mem_address;
        logic [BYTE_W-1:0]  mem_write_data;
        logic               nmi_request;
        logic               vblank_flag;
        logic [ADDR_W-1:0]  current_address;
        logic [FX_W-1:0]    fine_x_scroll;
        logic [BYTE_W-1:0]  control_value;
        logic [BYTE_W-1:0]  mask_value;
    } result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] control;
        logic [BYTE_W-1:0] mask;
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] temp_addr;
        logic [ADDR_W-1:0] cur_addr;
        logic [FX_W-1:0]   fine_x;
        logic              toggle;
        logic [BYTE_W-1:0] read_buf;
    } state_t;

endpackage

[hdl/video_register_port_scroll_unit.sv]
// Top level of the register port and scroll address unit
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: write_data, mem_read_data
//                                              tuser: kind, reg_index
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: result fields
//
// One beat per cycle unless m_axis_tready stalls; path: input register, then result register.
// All state updates happen in one combinational pass as a beat moves to the result register.
// Reset (rst_n low, asynchronous) clears all scroll, control and status state.
// While a result waits on m_axis_tready, one more beat is held in the input register.
module video_register_port_scroll_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // write_data[7:0], mem_read_data[15:8]
    input  logic [vrpsu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // kind[2:0], reg_index[5:3]
    input  logic [vrpsu_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_data[7:0], mem_write_strobe[8], mem_address[22:9], mem_write_data[30:23],
    // nmi_request[31], vblank_flag[32], current_address[48:33], fine_x_scroll[51:49],
    // control_value[59:52], mask_value[67:60], zero[71:68]
    output logic [vrpsu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic                in_valid_reg;
    vrpsu_pkg::item_t    in_item_reg;
    logic                out_valid_reg;
    vrpsu_pkg::result_t  out_result_reg;
    vrpsu_pkg::state_t   state_reg;
    vrpsu_pkg::state_t   state_next;
    vrpsu_pkg::result_t  result_next;
    logic                advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    vrpsu_core u_core
    (
        .item       (in_item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.kind          <= s_axis_tuser[2:0];
            in_item_reg.reg_index     <= s_axis_tuser[5:3];
            in_item_reg.write_data    <= s_axis_tdata[7:0];
            in_item_reg.mem_read_data <= s_axis_tdata[15:8];
        end
        if (advance)
            out_result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0,
                            out_result_reg.mask_value,
                            out_result_reg.control_value,
                            out_result_reg.fine_x_scroll,
                            out_result_reg.current_address,
                            out_result_reg.vblank_flag,
                            out_result_reg.nmi_request,
                            out_result_reg.mem_write_data,
                            out_result_reg.mem_address,
                            out_result_reg.mem_write_strobe,
                            out_result_reg.read_data};

endmodule

[hdl/vrpsu_core.sv]
// Next-state and result logic for one register access or rendering event
module vrpsu_core
(
    input  vrpsu_pkg::item_t   item,
    input  vrpsu_pkg::state_t  state,
    output vrpsu_pkg::state_t  state_next,
    output vrpsu_pkg::result_t result
);

    logic                            render_on;
    logic [vrpsu_pkg::ADDR_W-1:0]    port_step;
    logic [vrpsu_pkg::ADDR_W-1:0]    port_next;
    logic [vrpsu_pkg::ADDR_W-1:0]    incx_addr;
    logic [vrpsu_pkg::ADDR_W-1:0]    incy_addr;
    logic [4:0]                      tile_row;
    logic [4:0]                      tile_row_next;
    logic                            flip_y;
    logic [vrpsu_pkg::MADDR_W-1:0]   port_addr;

    assign render_on = state.mask[3] | state.mask[4];
    assign port_step = state.control[2] ? vrpsu_pkg::STEP_ROW : vrpsu_pkg::STEP_ONE;
    assign port_next = state.cur_addr + port_step;
    assign port_addr = state.cur_addr[vrpsu_pkg::MADDR_W-1:0];
    assign tile_row  = state.cur_addr[9:5];

    // horizontal increment: wrap coarse X and flip nametable X
    always_comb
    begin
        incx_addr = state.cur_addr + vrpsu_pkg::STEP_ONE;
        if (state.cur_addr[4:0] == vrpsu_pkg::COARSE_LAST)
        begin
            incx_addr = state.cur_addr;
            incx_addr[4:0] = 5'd0;
            incx_addr[10] = ~state.cur_addr[10];
        end
    end

    // vertical increment: fine Y, then coarse Y with the last-visible-row wrap
    always_comb
    begin
        flip_y = 1'b0;
        tile_row_next = tile_row + 5'd1;
        if (tile_row == vrpsu_pkg::TILE_ROW_LAST_VIS)
        begin
            tile_row_next = 5'd0;
            flip_y = 1'b1;
        end
        else if (tile_row == vrpsu_pkg::COARSE_LAST)
        begin
            tile_row_next = 5'd0;
        end
        incy_addr = state.cur_addr;
        if (state.cur_addr[14:12] != 3'd7)
        begin
            incy_addr[14:12] = state.cur_addr[14:12] + 3'd1;
        end
        else
        begin
            incy_addr[14:12] = 3'd0;
            incy_addr[9:5] = tile_row_next;
            incy_addr[11] = state.cur_addr[11] ^ flip_y;
        end
    end

    always_comb
    begin
        state_next = state;
        result = '0;
        unique case (item.kind)
            vrpsu_pkg::KIND_CPU_READ:
            begin
                if (item.reg_index == vrpsu_pkg::REG_STATUS)
                begin
                    result.read_data = {state.status, state.read_buf[4:0]};
                    state_next.status[2] = 1'b0;
                    state_next.toggle = 1'b0;
                end
                else if (item.reg_index == vrpsu_pkg::REG_DATA)
                begin
                    result.mem_address = port_addr;
                    result.read_data = (port_addr >= vrpsu_pkg::PALETTE_BASE) ?
                                       item.mem_read_data : state.read_buf;
                    state_next.read_buf = item.mem_read_data;
                    state_next.cur_addr = port_next;
                end
            end
            vrpsu_pkg::KIND_CPU_WRITE:
            begin
                unique case (item.reg_index)
                    vrpsu_pkg::REG_CONTROL:
                    begin
                        state_next.control = item.write_data;
                        state_next.temp_addr[11:10] = item.write_data[1:0];
                    end
                    vrpsu_pkg::REG_MASK:
                    begin
                        state_next.mask = item.write_data;
                    end
                    vrpsu_pkg::REG_SCROLL:
                    begin
                        if (!state.toggle)
                        begin
                            state_next.fine_x = item.write_data[2:0];
                            state_next.temp_addr[4:0] = item.write_data[7:3];
                        end
                        else
                        begin
                            state_next.temp_addr[14:12] = item.write_data[2:0];
                            state_next.temp_addr[9:5] = item.write_data[7:3];
                        end
                        state_next.toggle = ~state.toggle;
                    end
                    vrpsu_pkg::REG_ADDRESS:
                    begin
                        if (!state.toggle)
                        begin
                            state_next.temp_addr[14:8] = {1'b0, item.write_data[5:0]};
                        end
                        else
                        begin
                            state_next.temp_addr[7:0] = item.write_data;
                            state_next.cur_addr = {state.temp_addr[15:8], item.write_data};
                        end
                        state_next.toggle = ~state.toggle;
                    end
                    vrpsu_pkg::REG_DATA:
                    begin
                        result.mem_write_strobe = 1'b1;
                        result.mem_address = port_addr;
                        result.mem_write_data = item.write_data;
                        state_next.cur_addr = port_next;
                    end
                    default:
                    begin
                        state_next = state;
                    end
                endcase
            end
            vrpsu_pkg::KIND_INC_X:
            begin
                if (render_on)
                    state_next.cur_addr = incx_addr;
            end
            vrpsu_pkg::KIND_INC_Y:
            begin
                if (render_on)
                    state_next.cur_addr = incy_addr;
            end
            vrpsu_pkg::KIND_COPY_X:
            begin
                if (render_on)
                begin
                    state_next.cur_addr[4:0] = state.temp_addr[4:0];
                    state_next.cur_addr[10] = state.temp_addr[10];
                end
            end
            vrpsu_pkg::KIND_COPY_Y:
            begin
                if (render_on)
                begin
                    state_next.cur_addr[9:5] = state.temp_addr[9:5];
                    state_next.cur_addr[14:11] = state.temp_addr[14:11];
                end
            end
            vrpsu_pkg::KIND_VBL_START:
            begin
                state_next.status[2] = 1'b1;
                result.nmi_request = state.control[7];
            end
            vrpsu_pkg::KIND_VBL_END:
            begin
                state_next.status = '0;
            end
        endcase
        result.vblank_flag     = state_next.status[2];
        result.current_address = state_next.cur_addr;
        result.fine_x_scroll   = state_next.fine_x;
        result.control_value   = state_next.control;
        result.mask_value      = state_next.mask;
    end

endmodule

[hdl/vrpsu_checker.sv]
// Port-level assertion checker for the scroll unit, with its bind
`include "video_register_port_scroll_unit_macros.svh"

module vrpsu_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [vrpsu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    logic       nmi_bit;
    logic       vbl_bit;
    logic       strobe_bit;
    logic [7:0] rdata_byte;
    logic [7:0] wdata_byte;
    logic       out_stall;

    assign nmi_bit    = m_axis_tdata[31];
    assign vbl_bit    = m_axis_tdata[32];
    assign strobe_bit = m_axis_tdata[8];
    assign rdata_byte = m_axis_tdata[7:0];
    assign wdata_byte = m_axis_tdata[30:23];
    assign out_stall  = m_axis_tvalid && !m_axis_tready;

    `VRPSU_ASSERT_IMP(a_nmi_sets_vbl, clk, rst_n, m_axis_tvalid && nmi_bit, vbl_bit)
    `VRPSU_ASSERT_IMP(a_wr_no_rdata, clk, rst_n, m_axis_tvalid && strobe_bit, rdata_byte == 8'd0)
    `VRPSU_ASSERT_IMP(a_wdata_only_on_wr, clk, rst_n, m_axis_tvalid && !strobe_bit, wdata_byte == 8'd0)
    `VRPSU_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `VRPSU_ASSERT_IMP(a_in_block, clk, rst_n, !s_axis_tready, out_stall)

endmodule

bind video_register_port_scroll_unit vrpsu_checker u_vrpsu_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[bench/tb_video_register_port_scroll_unit.sv]
// Self-checking bench for the register port and scroll address unit: directed table, then random beats
module tb_video_register_port_scroll_unit;

    logic                              clk;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [vrpsu_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // write_data[7:0], mem_read_data[15:8]
    logic [vrpsu_pkg::IN_TUSER_W-1:0]  s_axis_tuser;   // kind[2:0], reg_index[5:3]
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    // read_data, strobe, mem addr, mem data, nmi, vblank,
    // current addr, fine x, control, mask (low bit up)
    logic [vrpsu_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    video_register_port_scroll_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    localparam int RANDOM_BEATS = 1300;
    localparam int DIR_N        = 33;

    // shadow of the unit's registers
    logic [vrpsu_pkg::BYTE_W-1:0] ctl_q    = '0;
    logic [vrpsu_pkg::BYTE_W-1:0] msk_q    = '0;
    logic [vrpsu_pkg::STAT_W-1:0] stat_q   = '0;
    logic [vrpsu_pkg::ADDR_W-1:0] tmp_addr = '0;
    logic [vrpsu_pkg::ADDR_W-1:0] cur_addr = '0;
    logic [vrpsu_pkg::FX_W-1:0]   fine_x   = '0;
    logic                         latch_w  = 1'b0;
    logic [vrpsu_pkg::BYTE_W-1:0] rd_buf   = '0;

    vrpsu_pkg::result_t port_results_due [$];
    int                 bad_count = 0;
    bit                 calm      = 1'b0;

    // typed rows: fields not listed are zero
    typedef struct {
        logic [vrpsu_pkg::KIND_W-1:0] kind;
        logic [vrpsu_pkg::REG_W-1:0]  regn;
        logic [7:0]                   wd;
        logic [7:0]                   md;
        bit                           typed;
        logic [7:0]                   rd;
        bit                           nmi;
        bit                           vbl;
        logic [7:0]                   ctl;
    } dir_row_t;

    dir_row_t dir_tab [DIR_N] = '{
        '{vrpsu_pkg::KIND_CPU_READ, vrpsu_pkg::REG_STATUS,
          8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_READ, vrpsu_pkg::REG_CONTROL,
          8'h00, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_STATUS,
          8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_CONTROL,
          8'hFF, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 8'hFF},
        '{vrpsu_pkg::KIND_VBL_START, vrpsu_pkg::REG_CONTROL,
          8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 1'b1, 8'hFF},
        '{vrpsu_pkg::KIND_CPU_READ, vrpsu_pkg::REG_STATUS,
          8'h00, 8'h00, 1'b1, 8'h80, 1'b0, 1'b0, 8'hFF},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_OAMADDR,
          8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_READ, vrpsu_pkg::REG_MASK,
          8'h00, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_READ, vrpsu_pkg::REG_OAMDATA,
          8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_INC_X, vrpsu_pkg::REG_DATA,
          8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_ADDRESS,
          8'h3F, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_ADDRESS,
          8'h1F, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_READ, vrpsu_pkg::REG_DATA,
          8'h00, 8'hAB, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_CONTROL,
          8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_DATA,
          8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_ADDRESS,
          8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_ADDRESS,
          8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_READ, vrpsu_pkg::REG_DATA,
          8'h00, 8'h55, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_MASK,
          8'h18, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_SCROLL,
          8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_READ, vrpsu_pkg::REG_STATUS,
          8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_SCROLL,
          8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_SCROLL,
          8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_COPY_X, vrpsu_pkg::REG_CONTROL,
          8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_COPY_Y, vrpsu_pkg::REG_CONTROL,
          8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_INC_X, vrpsu_pkg::REG_CONTROL,
          8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_INC_Y, vrpsu_pkg::REG_CONTROL,
          8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_SCROLL,
          8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_CPU_WRITE, vrpsu_pkg::REG_SCROLL,
          8'hEF, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_COPY_Y, vrpsu_pkg::REG_CONTROL,
          8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_INC_Y, vrpsu_pkg::REG_CONTROL,
          8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_VBL_START, vrpsu_pkg::REG_DATA,
          8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        '{vrpsu_pkg::KIND_VBL_END, vrpsu_pkg::REG_DATA,
          8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00}
    };

    function automatic vrpsu_pkg::result_t scroll_port_step(input vrpsu_pkg::item_t it);
        vrpsu_pkg::result_t           r;
        logic [vrpsu_pkg::ADDR_W-1:0] step;
        logic [4:0]                   cy;
        logic                         rendering;
        r = '0;
        rendering = |msk_q[4:3];
        step = ctl_q[2] ? vrpsu_pkg::STEP_ROW : vrpsu_pkg::STEP_ONE;
        case (it.kind)
            vrpsu_pkg::KIND_CPU_READ:
            begin
                if (it.reg_index == vrpsu_pkg::REG_STATUS)
                begin
                    r.read_data = {stat_q, rd_buf[4:0]};
                    stat_q[2] = 1'b0;
                    latch_w = 1'b0;
                end
                else if (it.reg_index == vrpsu_pkg::REG_DATA)
                begin
                    r.mem_address = cur_addr[vrpsu_pkg::MADDR_W-1:0];
                    r.read_data = rd_buf;
                    rd_buf = it.mem_read_data;
                    if (cur_addr[vrpsu_pkg::MADDR_W-1:0] >= vrpsu_pkg::PALETTE_BASE)
                        r.read_data = rd_buf;
                    cur_addr = cur_addr + step;
                end
            end
            vrpsu_pkg::KIND_CPU_WRITE:
            begin
                case (it.reg_index)
                    vrpsu_pkg::REG_CONTROL:
                    begin
                        ctl_q = it.write_data;
                        tmp_addr[11:10] = it.write_data[1:0];
                    end
                    vrpsu_pkg::REG_MASK:
                        msk_q = it.write_data;
                    vrpsu_pkg::REG_SCROLL:
                    begin
                        if (!latch_w)
                        begin
                            fine_x = it.write_data[2:0];
                            tmp_addr[4:0] = it.write_data[7:3];
                        end
                        else
                        begin
                            tmp_addr[14:12] = it.write_data[2:0];
                            tmp_addr[9:5] = it.write_data[7:3];
                        end
                        latch_w = ~latch_w;
                    end
                    vrpsu_pkg::REG_ADDRESS:
                    begin
                        if (!latch_w)
                        begin
                            tmp_addr[13:8] = it.write_data[5:0];
                            tmp_addr[14] = 1'b0;
                        end
                        else
                        begin
                            tmp_addr[7:0] = it.write_data;
                            cur_addr = tmp_addr;
                        end
                        latch_w = ~latch_w;
                    end
                    vrpsu_pkg::REG_DATA:
                    begin
                        r.mem_write_strobe = 1'b1;
                        r.mem_address = cur_addr[vrpsu_pkg::MADDR_W-1:0];
                        r.mem_write_data = it.write_data;
                        cur_addr = cur_addr + step;
                    end
                    default:
                    begin
                    end
                endcase
            end
            vrpsu_pkg::KIND_INC_X:
            begin
                if (rendering)
                begin
                    if (cur_addr[4:0] == vrpsu_pkg::COARSE_LAST)
                    begin
                        cur_addr[4:0] = '0;
                        cur_addr[10] = ~cur_addr[10];
                    end
                    else
                        cur_addr = cur_addr + 16'd1;
                end
            end
            vrpsu_pkg::KIND_INC_Y:
            begin
                if (rendering)
                begin
                    if (cur_addr[14:12] != 3'd7)
                        cur_addr = cur_addr + 16'h1000;
                    else
                    begin
                        cur_addr[14:12] = '0;
                        cy = cur_addr[9:5];
                        if (cy == vrpsu_pkg::TILE_ROW_LAST_VIS)
                        begin
                            cy = '0;
                            cur_addr[11] = ~cur_addr[11];
                        end
                        else if (cy == vrpsu_pkg::COARSE_LAST)
                            cy = '0;
                        else
                            cy = cy + 5'd1;
                        cur_addr[9:5] = cy;
                    end
                end
            end
            vrpsu_pkg::KIND_COPY_X:
            begin
                if (rendering)
                begin
                    cur_addr[10] = tmp_addr[10];
                    cur_addr[4:0] = tmp_addr[4:0];
                end
            end
            vrpsu_pkg::KIND_COPY_Y:
            begin
                if (rendering)
                begin
                    cur_addr[14:11] = tmp_addr[14:11];
                    cur_addr[9:5] = tmp_addr[9:5];
                end
            end
            vrpsu_pkg::KIND_VBL_START:
            begin
                stat_q[2] = 1'b1;
                r.nmi_request = ctl_q[7];
            end
            default:
                stat_q = '0;
        endcase
        r.vblank_flag = stat_q[2];
        r.current_address = cur_addr;
        r.fine_x_scroll = fine_x;
        r.control_value = ctl_q;
        r.mask_value = msk_q;
        return r;
    endfunction

    function automatic vrpsu_pkg::item_t random_beat();
        vrpsu_pkg::item_t it;
        int               pick;
        it.kind = vrpsu_pkg::KIND_CPU_READ;
        it.reg_index = 3'($urandom);
        it.write_data = 8'($urandom);
        it.mem_read_data = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 8)
            it.reg_index = vrpsu_pkg::REG_STATUS;
        else if (pick < 16)
            it.reg_index = vrpsu_pkg::REG_DATA;
        else if (pick < 19)
            it.kind = vrpsu_pkg::KIND_CPU_READ;
        else if (pick < 61)
        begin
            it.kind = vrpsu_pkg::KIND_CPU_WRITE;
            if (pick < 31)
                it.reg_index = vrpsu_pkg::REG_SCROLL;
            else if (pick < 41)
            begin
                it.reg_index = vrpsu_pkg::REG_ADDRESS;
                // steer toward the palette range now and then
                if ($urandom_range(3) == 0)
                    it.write_data[5:0] = 6'h3F;
            end
            else if (pick < 49)
                it.reg_index = vrpsu_pkg::REG_DATA;
            else if (pick < 53)
                it.reg_index = vrpsu_pkg::REG_CONTROL;
            else if (pick < 58)
            begin
                it.reg_index = vrpsu_pkg::REG_MASK;
                if ($urandom_range(4) != 0)
                    it.write_data[3 + $urandom_range(1)] = 1'b1;
            end
        end
        else if (pick < 88)
            it.kind = vrpsu_pkg::KIND_INC_X + 3'($urandom_range(3));
        else if (pick < 93)
            it.kind = vrpsu_pkg::KIND_VBL_START;
        else if (pick < 96)
            it.kind = vrpsu_pkg::KIND_VBL_END;
        else
            it.kind = 3'($urandom);
        return it;
    endfunction

    task automatic send_beat(input vrpsu_pkg::item_t it, input bit typed,
                             input vrpsu_pkg::result_t want);
        vrpsu_pkg::result_t predicted;
        while (!calm && $urandom_range(99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.mem_read_data, it.write_data};
        s_axis_tuser  <= {it.reg_index, it.kind};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = scroll_port_step(it);
        port_results_due.push_back(typed ? want : predicted);
    endtask

    function automatic void field_bad(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        bad_count++;
        if (bad_count <= 10)
            $display("mismatch %s: expected %h got %h", name, want, got);
    endfunction

    task automatic check_beat(input logic [vrpsu_pkg::OUT_TDATA_W-1:0] d);
        vrpsu_pkg::result_t got;
        vrpsu_pkg::result_t want;
        got.read_data        = d[7:0];
        got.mem_write_strobe = d[8];
        got.mem_address      = d[22:9];
        got.mem_write_data   = d[30:23];
        got.nmi_request      = d[31];
        got.vblank_flag      = d[32];
        got.current_address  = d[48:33];
        got.fine_x_scroll    = d[51:49];
        got.control_value    = d[59:52];
        got.mask_value       = d[67:60];
        if (port_results_due.size() == 0)
        begin
            bad_count++;
            if (bad_count <= 10)
                $display("result beat with none pending: %h", d);
            return;
        end
        want = port_results_due.pop_front();
        if (got.read_data !== want.read_data)
            field_bad("read_data", want.read_data, got.read_data);
        if (got.mem_write_strobe !== want.mem_write_strobe)
            field_bad("mem_write_strobe", want.mem_write_strobe, got.mem_write_strobe);
        if (got.mem_address !== want.mem_address)
            field_bad("mem_address", want.mem_address, got.mem_address);
        if (got.mem_write_data !== want.mem_write_data)
            field_bad("mem_write_data", want.mem_write_data, got.mem_write_data);
        if (got.nmi_request !== want.nmi_request)
            field_bad("nmi_request", want.nmi_request, got.nmi_request);
        if (got.vblank_flag !== want.vblank_flag)
            field_bad("vblank_flag", want.vblank_flag, got.vblank_flag);
        if (got.current_address !== want.current_address)
            field_bad("current_address", want.current_address, got.current_address);
        if (got.fine_x_scroll !== want.fine_x_scroll)
            field_bad("fine_x_scroll", want.fine_x_scroll, got.fine_x_scroll);
        if (got.control_value !== want.control_value)
            field_bad("control_value", want.control_value, got.control_value);
        if (got.mask_value !== want.mask_value)
            field_bad("mask_value", want.mask_value, got.mask_value);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                check_beat(m_axis_tdata);
            m_axis_tready <= calm || ($urandom_range(99) >= 9);
        end
    end

    initial
    begin
        vrpsu_pkg::item_t   it;
        vrpsu_pkg::result_t want;
        int                 i;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_N; i++)
        begin
            it.kind = dir_tab[i].kind;
            it.reg_index = dir_tab[i].regn;
            it.write_data = dir_tab[i].wd;
            it.mem_read_data = dir_tab[i].md;
            want = '0;
            want.read_data = dir_tab[i].rd;
            want.nmi_request = dir_tab[i].nmi;
            want.vblank_flag = dir_tab[i].vbl;
            want.control_value = dir_tab[i].ctl;
            send_beat(it, dir_tab[i].typed, want);
        end

        for (i = 0; i < RANDOM_BEATS; i++)
        begin
            calm = (i >= 500 && i < 800);
            send_beat(random_beat(), 1'b0, '0);
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (port_results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (bad_count == 0)
            $display("tb_video_register_port_scroll_unit OK");
        else
            $display("tb_video_register_port_scroll_unit NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_video_register_port_scroll_unit NOT OK");
        $finish;
    end

endmodule
